// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the interpolation table.
// PLI_ASSERT_IMP checks a same-cycle implication and PLI_ASSERT_NXT checks
// an implication in the next cycle. Both are disabled while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/pli_pkg.sv =====
`default_nettype none

package pli_pkg;

    // Request types.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Result case codes.
    localparam logic [2:0] CASE_INTERIOR   = 3'd0;
    localparam logic [2:0] CASE_BELOW      = 3'd1;
    localparam logic [2:0] CASE_ABOVE      = 3'd2;
    localparam logic [2:0] CASE_ZERO_WIDTH = 3'd3;
    localparam logic [2:0] CASE_SATURATED  = 3'd4;

    localparam logic [5:0] ENTRIES_RESET = 6'd2;

    localparam logic signed [31:0] RESULT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] RESULT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               req_type;
        logic [4:0]         entry_index;
        logic signed [31:0] entry_domain;
        logic signed [31:0] entry_range;
        logic signed [31:0] query_value;
    } t_request;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [2:0]         case_code;
    } t_result;

    // Query packet that walks the row of table cells.
    // Until a segment is found, d0/r0 track the most recent breakpoint.
    typedef struct packed {
        logic               valid;
        logic               first;
        logic               below;
        logic               above;
        logic               found;
        logic signed [31:0] q;
        logic signed [31:0] d0;
        logic signed [31:0] r0;
        logic signed [31:0] d1;
        logic signed [31:0] r1;
    } t_seg_pkt;

endpackage

`default_nettype wire

// ===== hw/rtl/pli_cell.sv =====
`default_nettype none

module pli_cell #(
    parameter int IW = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic signed [31:0]  i_wr_domain,
    input  logic signed [31:0]  i_wr_range,
    input  pli_pkg::t_seg_pkt   i_pkt,
    input  logic [IW-1:0]       i_rem,
    output pli_pkg::t_seg_pkt   o_pkt,
    output logic [IW-1:0]       o_rem
);

    logic signed [31:0] r_domain;
    logic signed [31:0] r_range;
    pli_pkg::t_seg_pkt  r_pkt;
    logic [IW-1:0]      r_rem;
    pli_pkg::t_seg_pkt  n_pkt;
    logic               w_active;
    logic               w_last;

    // The packet is live here until it has either fallen below the table
    // or closed its segment. i_rem counts down to zero at the last active entry.
    assign w_active = i_pkt.valid && !i_pkt.below && !i_pkt.found;
    assign w_last   = (i_rem == '0);

    always_comb begin
        n_pkt       = i_pkt;
        n_pkt.first = 1'b0;
        if (w_active) begin
            if (i_pkt.first) begin
                n_pkt.below = (i_pkt.q < r_domain);
                n_pkt.d0    = r_domain;
                n_pkt.r0    = r_range;
            end else if ((i_pkt.q <= r_domain) || w_last) begin
                n_pkt.found = 1'b1;
                n_pkt.d1    = r_domain;
                n_pkt.r1    = r_range;
            end else begin
                n_pkt.d0 = r_domain;
                n_pkt.r0 = r_range;
            end
        end
        // Above the last active breakpoint the answer is that entry's range.
        if (i_pkt.valid && !i_pkt.below && !i_pkt.first && w_last &&
            (i_pkt.q > r_domain)) begin
            n_pkt.above = 1'b1;
            n_pkt.r0    = r_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt.valid <= 1'b0;
        end else begin
            r_pkt <= n_pkt;
        end
        r_rem <= i_rem - 1'b1;
        if (i_wr_en) begin
            r_domain <= i_wr_domain;
            r_range  <= i_wr_range;
        end
    end

    assign o_pkt = r_pkt;
    assign o_rem = r_rem;

endmodule

`default_nettype wire

// ===== hw/rtl/pli_arith.sv =====
`default_nettype none

module pli_arith (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pli_pkg::t_seg_pkt i_seg,
    output logic              o_valid,
    output pli_pkg::t_result  o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV,
        S_FIN
    } t_state;

    t_state             r_state;
    logic [32:0]        r_pm;
    logic [32:0]        r_qm;
    logic [32:0]        r_dm;
    logic               r_neg;
    logic signed [31:0] r_r0;
    logic [2:0]         r_step;
    logic [33:0]        r_prod;
    logic [1:0]         r_pj;
    logic [65:0]        r_acc;
    logic [65:0]        r_rem;
    logic [65:0]        r_dsh;
    logic [33:0]        r_quo;
    logic [5:0]         r_cnt;

    logic [32:0] w_dr;
    logic [32:0] w_dq;
    logic [32:0] w_dd;
    logic [16:0] w_mul_a;
    logic [16:0] w_mul_b;
    logic [33:0] w_prod;
    logic [65:0] w_pp;
    logic        w_too_big;
    logic        w_ge;
    logic [65:0] w_sub;
    logic [34:0] w_r0x;
    logic [34:0] w_qx;
    logic [34:0] w_sum;
    logic        w_quo_big;

    // Differences are taken at 33 bits so that none of them can wrap.
    assign w_dr = {i_seg.r1[31], i_seg.r1} - {i_seg.r0[31], i_seg.r0};
    assign w_dq = {i_seg.q[31], i_seg.q} - {i_seg.d0[31], i_seg.d0};
    assign w_dd = {i_seg.d1[31], i_seg.d1} - {i_seg.d0[31], i_seg.d0};

    // One 17x17 multiplier builds the 33x33 product from four partial products.
    assign w_mul_a = r_step[1] ? r_pm[32:16] : {1'b0, r_pm[15:0]};
    assign w_mul_b = r_step[0] ? r_qm[32:16] : {1'b0, r_qm[15:0]};
    assign w_prod  = 34'(w_mul_a * w_mul_b);

    always_comb begin
        unique case (r_pj)
            2'd0:    w_pp = 66'(r_prod);
            2'd3:    w_pp = 66'(r_prod) << 32;
            default: w_pp = 66'(r_prod) << 16;
        endcase
    end

    // A quotient of 2^34 or more saturates in any case, so the divider only
    // needs to develop 34 quotient bits.
    assign w_too_big = ({1'b0, r_acc} >= {r_dm, 34'b0});
    assign w_ge      = (r_rem >= r_dsh);
    assign w_sub     = r_rem - r_dsh;

    assign w_r0x     = {{3{r_r0[31]}}, r_r0};
    assign w_qx      = {1'b0, r_quo};
    assign w_sum     = r_neg ? (w_r0x - w_qx) : (w_r0x + w_qx);
    assign w_quo_big = (r_quo > 34'h2_0000_0000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_seg.valid) begin
                        r_r0 <= i_seg.r0;
                        if (i_seg.below) begin
                            o_valid                <= 1'b1;
                            o_result.result_value <= i_seg.r0;
                            o_result.case_code    <= pli_pkg::CASE_BELOW;
                        end else if (i_seg.above) begin
                            o_valid                <= 1'b1;
                            o_result.result_value <= i_seg.r0;
                            o_result.case_code    <= pli_pkg::CASE_ABOVE;
                        end else if (i_seg.d1 == i_seg.d0) begin
                            o_valid                <= 1'b1;
                            o_result.result_value <= i_seg.r0;
                            o_result.case_code    <= pli_pkg::CASE_ZERO_WIDTH;
                        end else begin
                            r_pm    <= w_dr[32] ? (33'd0 - w_dr) : w_dr;
                            r_qm    <= w_dq[32] ? (33'd0 - w_dq) : w_dq;
                            r_dm    <= w_dd[32] ? (33'd0 - w_dd) : w_dd;
                            r_neg   <= w_dr[32] ^ w_dq[32] ^ w_dd[32];
                            r_acc   <= '0;
                            r_step  <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (r_step != 3'd4) begin
                        r_prod <= w_prod;
                        r_pj   <= r_step[1:0];
                    end
                    if (r_step != 3'd0) begin
                        r_acc <= r_acc + w_pp;
                    end
                    if (r_step == 3'd4) begin
                        r_state <= S_CHK;
                    end
                    r_step <= r_step + 3'd1;
                end
                S_CHK: begin
                    if (w_too_big) begin
                        o_valid                <= 1'b1;
                        o_result.result_value <= r_neg ? pli_pkg::RESULT_MIN
                                                       : pli_pkg::RESULT_MAX;
                        o_result.case_code    <= pli_pkg::CASE_SATURATED;
                        r_state                <= S_IDLE;
                    end else begin
                        r_rem   <= r_acc;
                        r_dsh   <= {r_dm, 33'b0};
                        r_quo   <= '0;
                        r_cnt   <= 6'd33;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_ge) begin
                        r_rem <= w_sub;
                    end
                    r_quo <= {r_quo[32:0], w_ge};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                    if (w_quo_big) begin
                        o_result.result_value <= r_neg ? pli_pkg::RESULT_MIN
                                                       : pli_pkg::RESULT_MAX;
                        o_result.case_code    <= pli_pkg::CASE_SATURATED;
                    end else if (w_sum[34:31] == 4'b0000 || w_sum[34:31] == 4'b1111) begin
                        o_result.result_value <= w_sum[31:0];
                        o_result.case_code    <= pli_pkg::CASE_INTERIOR;
                    end else begin
                        o_result.result_value <= w_sum[34] ? pli_pkg::RESULT_MIN
                                                           : pli_pkg::RESULT_MAX;
                        o_result.case_code    <= pli_pkg::CASE_SATURATED;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/piecewise_linear_interpolator_top.sv =====
// Channel     Direction  Handshake                        Payload
// request     in         start high, busy low             i_req     (pli_pkg::t_request)
// result      out        o_result_strobe, one cycle       o_result  (pli_pkg::t_result)
// config      in         i_cfg_valid and o_cfg_ready      i_cfg_data (entries in use)
//
// A load request writes its breakpoint at the accepting edge and busy stays low.
// A query request walks the TABLE_DEPTH cells, one per cycle, and then enters the arithmetic
// unit, which strobes from its idle state outside the table or on a zero-width segment;
// an interior point passes multiply, range check, divide and final sum, or strobes at the check if it saturates.
// Busy holds from acceptance through the strobe. Reset is synchronous and active low; it
// sets entries in use to 2 and leaves the table undefined. The receiver cannot stall.
`default_nettype none

`include "assert_macros.svh"

module piecewise_linear_interpolator_top #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pli_pkg::t_request  i_req,
    output logic               o_result_strobe,
    output pli_pkg::t_result   o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [5:0]         i_cfg_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic              r_busy;
    logic [5:0]        r_entries;

    logic              w_accept;
    logic              w_load_acc;
    logic              w_query_acc;
    logic [IW-1:0]     w_nm1;
    logic [IW-1:0]     w_slot;
    logic [IW-1:0]     w_slot_lut [32];
    logic [TABLE_DEPTH-1:0] w_wr_en;
    pli_pkg::t_seg_pkt w_pkt [TABLE_DEPTH+1];
    logic [IW-1:0]     w_rem [TABLE_DEPTH+1];

    assign w_accept    = start && !r_busy;
    assign w_load_acc  = w_accept && (i_req.req_type == pli_pkg::REQ_LOAD);
    assign w_query_acc = w_accept && (i_req.req_type == pli_pkg::REQ_QUERY);

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    // The active count is clamped to the range the table supports; the scan
    // carries the index of the last active breakpoint.
    always_comb begin
        if (r_entries < 6'd2) begin
            w_nm1 = IW'(1);
        end else if (32'(r_entries) > 32'(TABLE_DEPTH)) begin
            w_nm1 = IW'(TABLE_DEPTH - 1);
        end else begin
            w_nm1 = IW'(32'(r_entries) - 32'd1);
        end
    end

    // Slot indexes wrap modulo the table depth. The wrap is folded into a
    // constant lookup over the 32 possible index values.
    for (genvar j = 0; j < 32; j++) begin : g_slot
        assign w_slot_lut[j] = IW'(j % TABLE_DEPTH);
    end
    assign w_slot = w_slot_lut[i_req.entry_index];

    // Head of the chain: a fresh query packet enters the first cell.
    always_comb begin
        w_pkt[0]       = '0;
        w_pkt[0].valid = w_query_acc;
        w_pkt[0].first = 1'b1;
        w_pkt[0].q     = i_req.query_value;
    end
    assign w_rem[0] = w_nm1;

    // Each cell holds one breakpoint and hands the query packet onward.
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        assign w_wr_en[k] = w_load_acc && (w_slot == IW'(k));
        pli_cell #(.IW(IW)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (w_wr_en[k]),
            .i_wr_domain (i_req.entry_domain),
            .i_wr_range  (i_req.entry_range),
            .i_pkt       (w_pkt[k]),
            .i_rem       (w_rem[k]),
            .o_pkt       (w_pkt[k+1]),
            .o_rem       (w_rem[k+1])
        );
    end

    // The arithmetic unit finishes the query once the packet leaves the row.
    pli_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_seg    (w_pkt[TABLE_DEPTH]),
        .o_valid  (o_result_strobe),
        .o_result (o_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_entries <= pli_pkg::ENTRIES_RESET;
        end else begin
            if (w_query_acc) begin
                r_busy <= 1'b1;
            end else if (o_result_strobe) begin
                r_busy <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_entries <= i_cfg_data;
            end
        end
    end

    // A result only appears while a query is outstanding.
    `PLI_ASSERT_IMP(a_result_in_flight, i_clk, i_rst_n, o_result_strobe, r_busy, "result without query")
    // A packet leaving the row has either closed a segment or fallen below it.
    `PLI_ASSERT_IMP(a_scan_resolved, i_clk, i_rst_n, w_pkt[TABLE_DEPTH].valid, w_pkt[TABLE_DEPTH].found || w_pkt[TABLE_DEPTH].below, "scan unresolved")
    // An accepted query holds off further requests.
    `PLI_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, w_query_acc, busy, "query did not raise busy")
    // A load completes at the accepting edge and never makes the block busy.
    `PLI_ASSERT_NXT(a_load_idle, i_clk, i_rst_n, w_load_acc, !busy, "load raised busy")

endmodule

`default_nettype wire
